// ===== src/ctr_pkg.sv =====
// Shared types and codes of the chunked transfer reassembler.
`default_nettype none
package ctr_pkg;

  localparam int CHUNK_BYTES_DEF = 1024;
  localparam int MAX_CHUNKS_DEF  = 1024;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NOT_RECV = 4'd1;
  localparam logic [3:0] ST_SHORT    = 4'd2;
  localparam logic [3:0] ST_ZERO     = 4'd3;
  localparam logic [3:0] ST_INDEX    = 4'd4;
  localparam logic [3:0] ST_OVERFLOW = 4'd5;
  localparam logic [3:0] ST_DUP      = 4'd6;
  localparam logic [3:0] ST_FOREIGN  = 4'd7;
  localparam logic [3:0] ST_CAPACITY = 4'd8;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [10:0] START_MIN_LEN  = 11'd8;
  localparam logic [10:0] HEADER_MIN_LEN = 11'd5;
  localparam logic [10:0] HEADER_WORDS   = 11'd4;
  localparam int          PERCENT        = 100;

  typedef enum logic [2:0] {
    OP_START, OP_HDR, OP_DATA, OP_END, OP_READ, OP_FOREIGN
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        short8;
    logic        short5;
    logic        zero_sc;
    logic        over_cap;
    logic        idx_ovf;
    logic [10:0] size;
    logic [31:0] idx;
    logic [31:0] fsize;
    logic [31:0] count;
    logic [7:0]  data;
    logic [19:0] addr;
  } item_t;

endpackage
`default_nettype wire

// ===== src/chunked_transfer_reassembler.sv =====
// Top level of the chunked transfer reassembler.
// Usage:
//   Requests enter on start/in_* and are taken at a clock edge where start is
//   high and busy is low. Each request yields exactly one result on out_*,
//   shown for one cycle with out_strobe high; the receiver cannot stall.
//   A two-entry queue sits between intake and execution, so busy rises only
//   when two requests wait.
// Path from acceptance to out_strobe, after the queue entry:
//   data, end, foreign, rejected requests: decided in S_IDLE.
//   read, duplicate chunk header: S_RD or S_HDR_CHK (store or bitmap read).
//   accepted new chunk header: S_HDR_CHK, then S_DIV until the serial
//   percentage divider signals done.
//   accepted start: S_CLEAR over max(file_size, chunk_count) entries,
//   one store entry cleared per cycle.
// Throughput: one data or end request per cycle while the queue drains.
// Reset: synchronous, rst_n low; state goes to idle, counts to zero and the
//   byte store reads as zero until a start clears it.
`default_nettype none
module chunked_transfer_reassembler
  import ctr_pkg::*;
#(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [10:0] in_payload_length,
  input  wire logic [31:0] in_file_size,
  input  wire logic [31:0] in_chunk_count,
  input  wire logic [31:0] in_chunk_index,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [19:0] in_read_address,
  output logic             out_strobe,
  output logic [3:0]       out_status,
  output logic [1:0]       out_transfer_state,
  output logic [10:0]      out_received_chunks,
  output logic [6:0]       out_progress_percent,
  output logic [10:0]      out_missing_chunks,
  output logic [7:0]       out_read_data
);

  logic  q_valid, q_pop;
  item_t q_item;

  ctr_front #(.CHUNK_BYTES(CHUNK_BYTES), .MAX_CHUNKS(MAX_CHUNKS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_payload_length(in_payload_length),
    .in_file_size(in_file_size), .in_chunk_count(in_chunk_count),
    .in_chunk_index(in_chunk_index), .in_data_byte(in_data_byte),
    .in_read_address(in_read_address),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  ctr_back #(.CHUNK_BYTES(CHUNK_BYTES), .MAX_CHUNKS(MAX_CHUNKS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_transfer_state(out_transfer_state),
    .out_received_chunks(out_received_chunks),
    .out_progress_percent(out_progress_percent),
    .out_missing_chunks(out_missing_chunks), .out_read_data(out_read_data)
  );

endmodule
`default_nettype wire

// ===== src/ctr_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module ctr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

// ===== src/ctr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module ctr_div #(
  parameter int NW = 18,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic      [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], quo_r[NW-1]};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== src/ctr_front.sv =====
// Request intake: decode, early checks and a two-entry queue.
`default_nettype none
module ctr_front
  import ctr_pkg::*;
#(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [10:0] in_payload_length,
  input  wire logic [31:0] in_file_size,
  input  wire logic [31:0] in_chunk_count,
  input  wire logic [31:0] in_chunk_index,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [19:0] in_read_address,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  localparam longint STORE = longint'(CHUNK_BYTES) * longint'(MAX_CHUNKS);

  item_t      mem_r [2];
  item_t      it;
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  always_comb begin
    it = '0;
    unique case (in_kind)
      KIND_START:  it.op = OP_START;
      KIND_HEADER: it.op = OP_HDR;
      KIND_DATA:   it.op = OP_DATA;
      KIND_END:    it.op = OP_END;
      KIND_READ:   it.op = OP_READ;
      default:     it.op = OP_FOREIGN;
    endcase
    it.short8   = in_payload_length < START_MIN_LEN;
    it.short5   = in_payload_length < HEADER_MIN_LEN;
    it.zero_sc  = (in_file_size == '0) || (in_chunk_count == '0);
    it.over_cap = (64'(in_file_size) > 64'(STORE)) ||
                  (64'(in_chunk_count) > 64'(MAX_CHUNKS));
    it.idx_ovf  = 64'(in_chunk_index) >= 64'(MAX_CHUNKS);
    it.size     = in_payload_length - HEADER_WORDS;
    it.idx      = in_chunk_index;
    it.fsize    = in_file_size;
    it.count    = in_chunk_count;
    it.data     = in_data_byte;
    it.addr     = in_read_address;
  end

  assign busy    = cnt_r == 2'd2;
  assign push    = start && !busy;
  assign q_valid = cnt_r != 2'd0;
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
    if (push) begin
      mem_r[wr_ptr_r] <= it;
    end
  end

endmodule
`default_nettype wire

// ===== src/ctr_back.sv =====
// Request execution: transfer state, byte store, chunk bitmap and results.
`default_nettype none
module ctr_back
  import ctr_pkg::*;
#(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             out_strobe,
  output logic [3:0]       out_status,
  output logic [1:0]       out_transfer_state,
  output logic [10:0]      out_received_chunks,
  output logic [6:0]       out_progress_percent,
  output logic [10:0]      out_missing_chunks,
  output logic [7:0]       out_read_data
);

  localparam int STORE = CHUNK_BYTES * MAX_CHUNKS;
  localparam int SA    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int FBW   = $clog2(STORE + 1);
  localparam int CIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNW   = $clog2(MAX_CHUNKS + 1);
  localparam int NW    = CNW + 7;
  localparam int OW    = FBW + 12;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_HDR_CHK, S_DIV, S_RD
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic [FBW-1:0] fbytes_r, fbytes_nxt;
  logic [CNW-1:0] total_r, total_nxt;
  logic [CNW-1:0] recv_r, recv_nxt;
  logic [FBW-1:0] wp_r, wp_nxt;
  logic [10:0]    left_r, left_nxt;
  logic [6:0]     prog_r, prog_nxt;
  logic [FBW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [FBW-1:0] clr_len_r, clr_len_nxt;
  logic [CIW-1:0] hdr_idx_r, hdr_idx_nxt;
  logic           rd_ok_r, rd_ok_nxt;

  logic           emit;
  logic [3:0]     st;
  logic [10:0]    missing;

  logic           s_we;
  logic [SA-1:0]  s_addr;
  logic [7:0]     s_rdata;
  logic           b_we;
  logic [CIW-1:0] b_addr;
  logic           b_rdata;

  logic           div_start, div_done;
  logic [NW-1:0]  div_q;

  logic [CIW-1:0] idx_c;
  logic [OW-1:0]  end_pos;
  logic [FBW-1:0] fs_c, cnt_c;

  ctr_ram #(.WIDTH(8), .DEPTH(STORE)) u_store (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(8'd0 | (state_r == S_CLEAR ? 8'd0 : q_item.data)),
    .rdata(s_rdata)
  );

  ctr_ram #(.WIDTH(1), .DEPTH(MAX_CHUNKS)) u_bitmap (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(state_r != S_CLEAR), .rdata(b_rdata)
  );

  ctr_div #(.NW(NW), .DW(CNW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(NW'((recv_r + CNW'(1)) * PERCENT)), .divisor(total_r),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    fbytes_nxt  = fbytes_r;
    total_nxt   = total_r;
    recv_nxt    = recv_r;
    wp_nxt      = wp_r;
    left_nxt    = left_r;
    prog_nxt    = prog_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_len_nxt = clr_len_r;
    hdr_idx_nxt = hdr_idx_r;
    rd_ok_nxt   = rd_ok_r;
    emit        = 1'b0;
    st          = ST_OK;
    missing     = '0;
    q_pop       = 1'b0;
    s_we        = 1'b0;
    s_addr      = SA'(wp_r);
    b_we        = 1'b0;
    b_addr      = hdr_idx_r;
    div_start   = 1'b0;
    idx_c       = q_item.idx[CIW-1:0];
    fs_c        = FBW'(q_item.fsize);
    cnt_c       = FBW'(q_item.count);
    end_pos     = OW'(idx_c) * OW'(CHUNK_BYTES) + OW'(q_item.size);

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_START: begin
              phase_nxt  = PH_IDLE;
              fbytes_nxt = '0;
              total_nxt  = '0;
              recv_nxt   = '0;
              wp_nxt     = '0;
              left_nxt   = '0;
              prog_nxt   = '0;
              priority if (q_item.short8) begin
                phase_nxt = PH_FAIL;
                st        = ST_SHORT;
                emit      = 1'b1;
              end else if (q_item.zero_sc) begin
                phase_nxt = PH_FAIL;
                st        = ST_ZERO;
                emit      = 1'b1;
              end else if (q_item.over_cap) begin
                phase_nxt = PH_FAIL;
                st        = ST_CAPACITY;
                emit      = 1'b1;
              end else begin
                fbytes_nxt  = fs_c;
                total_nxt   = CNW'(q_item.count);
                clr_cnt_nxt = '0;
                clr_len_nxt = (fs_c > cnt_c) ? fs_c : cnt_c;
                state_nxt   = S_CLEAR;
              end
            end
            OP_HDR: begin
              left_nxt = '0;
              priority if (phase_r != PH_RECV) begin
                st   = ST_NOT_RECV;
                emit = 1'b1;
              end else if (q_item.short5) begin
                st   = ST_SHORT;
                emit = 1'b1;
              end else if (q_item.idx_ovf || q_item.idx >= 32'(total_r)) begin
                st   = ST_INDEX;
                emit = 1'b1;
              end else if (end_pos > OW'(fbytes_r)) begin
                phase_nxt = PH_FAIL;
                st        = ST_OVERFLOW;
                emit      = 1'b1;
              end else begin
                wp_nxt      = FBW'(OW'(idx_c) * OW'(CHUNK_BYTES));
                left_nxt    = q_item.size;
                hdr_idx_nxt = idx_c;
                b_addr      = idx_c;
                state_nxt   = S_HDR_CHK;
              end
            end
            OP_DATA: begin
              emit = 1'b1;
              if (phase_r != PH_RECV || left_r == '0) begin
                st = ST_NOT_RECV;
              end else begin
                s_we     = wp_r < fbytes_r;
                wp_nxt   = wp_r + FBW'(1);
                left_nxt = left_r - 11'd1;
              end
            end
            OP_END: begin
              emit = 1'b1;
              if (phase_r != PH_RECV) begin
                st = ST_NOT_RECV;
              end else begin
                missing   = 11'(total_r - recv_r);
                phase_nxt = PH_DONE;
                left_nxt  = '0;
              end
            end
            OP_READ: begin
              s_addr    = SA'(q_item.addr);
              rd_ok_nxt = 64'(q_item.addr) < 64'(fbytes_r);
              state_nxt = S_RD;
            end
            default: begin
              st   = ST_FOREIGN;
              emit = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        s_addr      = SA'(clr_cnt_r);
        s_we        = clr_cnt_r < fbytes_r;
        b_addr      = clr_cnt_r[CIW-1:0];
        b_we        = FBW'(clr_cnt_r) < FBW'(total_r);
        clr_cnt_nxt = clr_cnt_r + FBW'(1);
        if (clr_cnt_r == clr_len_r - FBW'(1)) begin
          phase_nxt = PH_RECV;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HDR_CHK: begin
        if (b_rdata) begin
          st        = ST_DUP;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          b_we      = 1'b1;
          div_start = 1'b1;
          recv_nxt  = recv_r + CNW'(1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          prog_nxt  = div_q[6:0];
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= PH_IDLE;
      fbytes_r   <= '0;
      total_r    <= '0;
      recv_r     <= '0;
      wp_r       <= '0;
      left_r     <= '0;
      prog_r     <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      fbytes_r   <= fbytes_nxt;
      total_r    <= total_nxt;
      recv_r     <= recv_nxt;
      wp_r       <= wp_nxt;
      left_r     <= left_nxt;
      prog_r     <= prog_nxt;
      out_strobe <= emit;
    end
    clr_cnt_r <= clr_cnt_nxt;
    clr_len_r <= clr_len_nxt;
    hdr_idx_r <= hdr_idx_nxt;
    rd_ok_r   <= rd_ok_nxt;
    if (emit) begin
      out_status           <= st;
      out_transfer_state   <= phase_nxt;
      out_received_chunks  <= 11'(recv_nxt);
      out_progress_percent <= (phase_nxt == PH_RECV) ? prog_nxt : 7'd0;
      out_missing_chunks   <= missing;
      out_read_data        <= (state_r == S_RD && rd_ok_r) ? s_rdata : 8'd0;
    end
  end

endmodule
`default_nettype wire

// ===== src/ctr_checker.sv =====
// Port-level checks of the reassembler, bound to the top level.
`default_nettype none
module ctr_checker
  import ctr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_strobe,
  input wire logic [3:0]  out_status,
  input wire logic [1:0]  out_transfer_state,
  input wire logic [6:0]  out_progress_percent,
  input wire logic [10:0] out_missing_chunks
);

  a_progress_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_transfer_state != PH_RECV |-> out_progress_percent == 7'd0)
    else $error("progress shown outside receiving");

  a_missing_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_missing_chunks != 11'd0 |-> out_transfer_state == PH_DONE)
    else $error("missing count without completion");

  a_overflow_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_OVERFLOW || out_status == ST_CAPACITY ||
                   out_status == ST_ZERO) |-> out_transfer_state == PH_FAIL)
    else $error("fatal status without failed state");

  a_progress_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_progress_percent <= 7'd100)
    else $error("progress above 100");

endmodule

bind chunked_transfer_reassembler ctr_checker u_ctr_checker (
  .clk(clk), .rst_n(rst_n), .out_strobe(out_strobe), .out_status(out_status),
  .out_transfer_state(out_transfer_state),
  .out_progress_percent(out_progress_percent),
  .out_missing_chunks(out_missing_chunks)
);
`default_nettype wire

// ===== tb/tb_chunked_transfer_reassembler.sv =====
// Testbench of the chunked transfer reassembler: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_chunked_transfer_reassembler;
  import ctr_pkg::*;

  localparam logic [2:0] KIND_OTHER = 3'd5;
  localparam int unsigned CHUNK = 1024;
  localparam int unsigned SLOTS = 1024;
  localparam longint unsigned CAPACITY = 64'd1048576;
  localparam int NUM_REQ = 1850;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  phase;
    logic [10:0] received;
    logic [6:0]  percent;
    logic [10:0] missing;
    logic [7:0]  rdata;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [10:0] in_payload_length;
  logic [31:0] in_file_size;
  logic [31:0] in_chunk_count;
  logic [31:0] in_chunk_index;
  logic [7:0]  in_data_byte;
  logic [19:0] in_read_address;
  logic        out_strobe;
  logic [3:0]  out_status;
  logic [1:0]  out_transfer_state;
  logic [10:0] out_received_chunks;
  logic [6:0]  out_progress_percent;
  logic [10:0] out_missing_chunks;
  logic [7:0]  out_read_data;

  chunked_transfer_reassembler i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_payload_length   (in_payload_length),
    .in_file_size        (in_file_size),
    .in_chunk_count      (in_chunk_count),
    .in_chunk_index      (in_chunk_index),
    .in_data_byte        (in_data_byte),
    .in_read_address     (in_read_address),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_transfer_state  (out_transfer_state),
    .out_received_chunks (out_received_chunks),
    .out_progress_percent(out_progress_percent),
    .out_missing_chunks  (out_missing_chunks),
    .out_read_data       (out_read_data)
  );

  // transfer model
  logic [1:0]  xfer_phase;
  int unsigned xfer_bytes;
  int unsigned xfer_chunks;
  int unsigned got_chunks;
  int unsigned wr_ptr;
  int unsigned wr_left;
  bit          chunk_seen [SLOTS];
  logic [7:0]  file_mem [int unsigned];

  result_t expected_results [$];
  int errors;
  int sent;
  int checked;
  bit steady;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void drop_transfer();
    xfer_phase = PH_IDLE;
    xfer_bytes = 0;
    xfer_chunks = 0;
    got_chunks = 0;
    wr_ptr = 0;
    wr_left = 0;
  endfunction

  function automatic result_t reassemble(input logic [2:0] kind, input logic [10:0] plen,
                                         input logic [31:0] fsize, input logic [31:0] count,
                                         input logic [31:0] idx, input logic [7:0] dbyte,
                                         input logic [19:0] addr);
    result_t r;
    longint unsigned offset;
    longint unsigned len;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_START: begin
        if (xfer_phase != PH_IDLE) drop_transfer();
        wr_left = 0;
        if (plen < START_MIN_LEN) begin
          xfer_phase = PH_FAIL;
          r.status = ST_SHORT;
        end else if (fsize == 0 || count == 0) begin
          xfer_phase = PH_FAIL;
          r.status = ST_ZERO;
        end else if (longint'(fsize) > CAPACITY || count > SLOTS) begin
          xfer_phase = PH_FAIL;
          r.status = ST_CAPACITY;
        end else begin
          xfer_bytes = fsize;
          xfer_chunks = count;
          file_mem.delete();
          foreach (chunk_seen[i]) chunk_seen[i] = 1'b0;
          got_chunks = 0;
          wr_ptr = 0;
          xfer_phase = PH_RECV;
        end
      end
      KIND_HEADER: begin
        wr_left = 0;
        if (xfer_phase != PH_RECV) r.status = ST_NOT_RECV;
        else if (plen < HEADER_MIN_LEN) r.status = ST_SHORT;
        else if (idx >= xfer_chunks || idx >= SLOTS) r.status = ST_INDEX;
        else begin
          len = plen - HEADER_WORDS;
          offset = longint'(idx) * CHUNK;
          if (offset + len > xfer_bytes) begin
            xfer_phase = PH_FAIL;
            r.status = ST_OVERFLOW;
          end else begin
            wr_ptr = offset;
            wr_left = len;
            if (chunk_seen[idx]) r.status = ST_DUP;
            else begin
              chunk_seen[idx] = 1'b1;
              got_chunks++;
            end
          end
        end
      end
      KIND_DATA: begin
        if (xfer_phase != PH_RECV || wr_left == 0) r.status = ST_NOT_RECV;
        else begin
          if (wr_ptr < CAPACITY && wr_ptr < xfer_bytes) file_mem[wr_ptr] = dbyte;
          wr_ptr++;
          wr_left--;
        end
      end
      KIND_END: begin
        if (xfer_phase != PH_RECV) r.status = ST_NOT_RECV;
        else begin
          r.missing = xfer_chunks - got_chunks;
          xfer_phase = PH_DONE;
          wr_left = 0;
        end
      end
      KIND_READ: begin
        if (addr < xfer_bytes && file_mem.exists(addr)) r.rdata = file_mem[addr];
      end
      default: r.status = ST_FOREIGN;
    endcase
    if (xfer_phase == PH_RECV && xfer_chunks != 0)
      r.percent = (longint'(got_chunks) * PERCENT) / xfer_chunks;
    r.phase = xfer_phase;
    r.received = got_chunks;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 45) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic [10:0] plen,
                              input logic [31:0] fsize, input logic [31:0] count,
                              input logic [31:0] idx, input logic [7:0] dbyte,
                              input logic [19:0] addr);
    int gap;
    @(negedge clk);
    start = 1'b1;
    in_kind = kind;
    in_payload_length = plen;
    in_file_size = fsize;
    in_chunk_count = count;
    in_chunk_index = idx;
    in_data_byte = dbyte;
    in_read_address = addr;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    expected_results.push_back(reassemble(kind, plen, fsize, count, idx, dbyte, addr));
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = expected_results.pop_front();
        checked++;
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status);
          errors++;
        end
        if (out_transfer_state !== e.phase) begin
          $error("transfer_state exp %0d got %0d", e.phase, out_transfer_state);
          errors++;
        end
        if (out_received_chunks !== e.received) begin
          $error("received_chunks exp %0d got %0d", e.received, out_received_chunks);
          errors++;
        end
        if (out_progress_percent !== e.percent) begin
          $error("progress_percent exp %0d got %0d", e.percent, out_progress_percent);
          errors++;
        end
        if (out_missing_chunks !== e.missing) begin
          $error("missing_chunks exp %0d got %0d", e.missing, out_missing_chunks);
          errors++;
        end
        if (out_read_data !== e.rdata) begin
          $error("read_data exp %0d got %0d", e.rdata, out_read_data);
          errors++;
        end
      end
    end
  end

  task automatic test_idle_requests();
    send_request(KIND_READ, 11'd0, 32'd0, 32'd0, 32'd0, 8'd0, 20'hFFFFF);
    send_request(KIND_DATA, 11'd0, 32'd0, 32'd0, 32'd0, 8'hFF, 20'd0);
    send_request(KIND_HEADER, 11'd20, 32'd0, 32'd0, 32'd0, 8'd0, 20'd0);
    send_request(KIND_END, 11'd0, 32'd0, 32'd0, 32'd0, 8'd0, 20'd0);
    send_request(KIND_OTHER, 11'h7FF, '1, '1, '1, 8'hFF, 20'hFFFFF);
    send_request(3'd7, 11'd0, 32'd0, 32'd0, 32'd0, 8'd0, 20'd0);
  endtask

  task automatic test_start_checks();
    send_request(KIND_START, 11'd7, 32'd100, 32'd1, 32'd0, 8'd0, 20'd0);
    send_request(KIND_START, 11'd8, 32'd0, 32'd1, 32'd0, 8'd0, 20'd0);
    send_request(KIND_START, 11'd8, 32'd100, 32'd0, 32'd0, 8'd0, 20'd0);
    send_request(KIND_START, 11'h7FF, 32'd1048577, 32'd4, 32'd0, 8'd0, 20'd0);
    send_request(KIND_START, 11'd8, 32'd100, 32'd1025, 32'd0, 8'd0, 20'd0);
    send_request(KIND_START, 11'd8, '1, '1, 32'd0, 8'd0, 20'd0);
  endtask

  task automatic test_full_file();
    send_request(KIND_START, 11'd8, 32'd1048576, 32'd1024, 32'd0, 8'd0, 20'd0);
    send_request(KIND_HEADER, 11'd4, 32'd0, 32'd0, 32'd0, 8'd0, 20'd0);
    send_request(KIND_HEADER, 11'd5, 32'd0, 32'd0, 32'd1024, 8'd0, 20'd0);
    send_request(KIND_HEADER, 11'd6, 32'd0, 32'd0, 32'd1023, 8'd0, 20'd0);
    send_request(KIND_DATA, 11'd0, 32'd0, 32'd0, 32'd0, 8'hA5, 20'd0);
    send_request(KIND_DATA, 11'd0, 32'd0, 32'd0, 32'd0, 8'hFF, 20'd0);
    send_request(KIND_DATA, 11'd0, 32'd0, 32'd0, 32'd0, 8'h00, 20'd0);
    send_request(KIND_HEADER, 11'd5, 32'd0, 32'd0, 32'd1023, 8'd0, 20'd0);
    send_request(KIND_DATA, 11'd0, 32'd0, 32'd0, 32'd0, 8'h5A, 20'd0);
    send_request(KIND_READ, 11'd0, 32'd0, 32'd0, 32'd0, 8'd0, 20'hFFC00);
    send_request(KIND_READ, 11'd0, 32'd0, 32'd0, 32'd0, 8'd0, 20'hFFC01);
    send_request(KIND_HEADER, 11'h7FF, 32'd0, 32'd0, 32'd1022, 8'd0, 20'd0);
    send_request(KIND_END, 11'd0, 32'd0, 32'd0, 32'd0, 8'd0, 20'd0);
    send_request(KIND_READ, 11'd0, 32'd0, 32'd0, 32'd0, 8'd0, 20'hFFC00);
    send_request(KIND_START, 11'd8, 32'd3000, 32'd3, 32'd0, 8'd0, 20'd0);
    send_request(KIND_HEADER, 11'd1000, 32'd0, 32'd0, 32'd2, 8'd0, 20'd0);
  endtask

  task automatic run_transfer();
    int unsigned count;
    int unsigned fsize;
    int unsigned idx;
    int unsigned room;
    int unsigned len;
    int n;
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
    fsize = (count - 1) * CHUNK + $urandom_range(1, CHUNK);
    send_request(KIND_START, $urandom_range(8, 2047), fsize, count, $urandom, $urandom,
                 $urandom);
    n = $urandom_range(1, count + 3);
    for (int c = 0; c < n && sent < NUM_REQ; c++) begin
      idx = ($urandom_range(0, 11) == 0) ? $urandom_range(count, count + 2) :
            $urandom_range(0, count - 1);
      room = (idx < count) ? fsize - idx * CHUNK : 1;
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) len = $urandom_range(1, 2043);
      else if (len > room) len = room;
      send_request(KIND_HEADER, len + 4, $urandom, $urandom, idx, $urandom, $urandom);
      for (int b = 0; b < len + $urandom_range(0, 1); b++)
        send_request(KIND_DATA, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 2) == 0)
        send_request(KIND_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, fsize + 2));
    end
    if ($urandom_range(0, 3) != 0)
      send_request(KIND_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat ($urandom_range(0, 3))
      send_request(KIND_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, fsize + 2));
  endtask

  task automatic test_random();
    bit paused;
    paused = 1'b0;
    while (sent < NUM_REQ) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) != 0) run_transfer();
      else begin
        repeat ($urandom_range(1, 6))
          send_request($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
      end
      if (!paused && sent > NUM_REQ / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    errors = 0;
    sent = 0;
    checked = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = '0;
    in_payload_length = '0;
    in_file_size = '0;
    in_chunk_count = '0;
    in_chunk_index = '0;
    in_data_byte = '0;
    in_read_address = '0;
    drop_transfer();
    foreach (chunk_seen[i]) chunk_seen[i] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_idle_requests();
    test_start_checks();
    test_full_file();
    test_random();
    @(negedge clk);
    start = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests over directed and random transfers, %0d results checked.",
             sent, checked);
    if (errors == 0) begin
      $display("tb_chunked_transfer_reassembler OK");
    end else begin
      $display("tb_chunked_transfer_reassembler NOT OK");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timed out with %0d results pending.", expected_results.size());
    $display("tb_chunked_transfer_reassembler NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
src/ctr_pkg.sv
src/ctr_ram.sv
src/ctr_div.sv
src/ctr_front.sv
src/ctr_back.sv
src/chunked_transfer_reassembler.sv
src/ctr_checker.sv
tb/tb_chunked_transfer_reassembler.sv
